// File: rtl/ajrb_pkg.sv
// Shared types and constants for the audio jitter ring buffer.
// No dependencies; used by every other file of the block except ajrb_ram.
package ajrb_pkg;

  localparam int BLOCK_SIZE_DEF = 32;
  localparam int RING_DEPTH_DEF = 128;
  localparam int SAMPLE_W       = 16;
  localparam int COUNT_W        = 32;

  typedef enum logic {
    MODE_PUSH  = 1'b0,
    MODE_DRAIN = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_SAMPLE  = 2'd1,
    KIND_REFUSED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  // Per-result control bits travelling from the controller to the result register.
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  last;
    logic  overflowed;
  } res_tag_t;

endpackage

// File: rtl/ajrb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ajrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ajrb_ctrl.sv
// Ring controller: pointers, fill count, drop counter and the drain sequencer.
// Depends on ajrb_pkg; drives the ring RAM ports and the next result tag.
module ajrb_ctrl #(
  parameter int BLOCK_SIZE = ajrb_pkg::BLOCK_SIZE_DEF,
  parameter int RING_DEPTH = ajrb_pkg::RING_DEPTH_DEF,
  localparam int PW = $clog2(RING_DEPTH),
  localparam int HW = $clog2(RING_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          mode,
  input  logic [7:0]                    high_byte,
  input  logic [7:0]                    low_byte,
  output logic                          busy,
  output logic                          ram_we,
  output logic [PW-1:0]                 ram_waddr,
  output logic [ajrb_pkg::SAMPLE_W-1:0] ram_wdata,
  output logic                          ram_re,
  output logic [PW-1:0]                 ram_raddr,
  output ajrb_pkg::res_tag_t            tag_next,
  output logic [HW-1:0]                 held,
  output logic [ajrb_pkg::COUNT_W-1:0]  drop_count
);

  localparam int CNT_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

  ajrb_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [PW-1:0]    wptr, rptr;

  logic accept, push, drain_req, enough, full, issue, issue_last;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    advance = (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign busy       = (state == ajrb_pkg::ST_DRAIN);
  assign accept     = start && (state == ajrb_pkg::ST_IDLE);
  assign push       = accept && (mode == ajrb_pkg::MODE_PUSH);
  assign drain_req  = accept && (mode == ajrb_pkg::MODE_DRAIN);
  assign enough     = (32'(held) >= 32'(BLOCK_SIZE));
  assign full       = (held == HW'(RING_DEPTH));
  assign issue      = (drain_req && enough) || (state == ajrb_pkg::ST_DRAIN);
  assign issue_last = (state == ajrb_pkg::ST_IDLE) ? (BLOCK_SIZE == 1)
                                                   : (cnt == CNT_W'(BLOCK_SIZE - 1));

  assign ram_we    = push;
  assign ram_waddr = wptr;
  assign ram_wdata = {high_byte, low_byte};
  assign ram_re    = issue;
  assign ram_raddr = rptr;

  always_comb begin
    tag_next = '0;
    if (push) begin
      tag_next.valid      = 1'b1;
      tag_next.kind       = ajrb_pkg::KIND_PUSH;
      tag_next.last       = 1'b1;
      tag_next.overflowed = full;
    end else if (drain_req && !enough) begin
      tag_next.valid = 1'b1;
      tag_next.kind  = ajrb_pkg::KIND_REFUSED;
      tag_next.last  = 1'b1;
    end else if (issue) begin
      // sample itself comes out of the RAM in the next cycle, alongside this tag
      tag_next.valid = 1'b1;
      tag_next.kind  = ajrb_pkg::KIND_SAMPLE;
      tag_next.last  = issue_last;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ajrb_pkg::ST_IDLE: begin
        if (issue && !issue_last) begin
          state_next = ajrb_pkg::ST_DRAIN;
          cnt_next   = CNT_W'(1);
        end
      end
      ajrb_pkg::ST_DRAIN: begin
        if (issue_last) begin
          state_next = ajrb_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      default: begin
        state_next = ajrb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ajrb_pkg::ST_IDLE;
      cnt        <= '0;
      wptr       <= '0;
      rptr       <= '0;
      held       <= '0;
      drop_count <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (push) begin
        wptr <= advance(wptr);
      end
      // a full push drops the oldest item by stepping past it
      if (issue || (push && full)) begin
        rptr <= advance(rptr);
      end
      if (push && full) begin
        drop_count <= drop_count + ajrb_pkg::COUNT_W'(1);
      end
      if (push && !full) begin
        held <= held + HW'(1);
      end else if (issue) begin
        held <= held - HW'(1);
      end
    end
  end

endmodule

// File: rtl/audio_jitter_ring_buffer_top.sv
// Top level of the audio jitter ring buffer.
// Depends on ajrb_pkg, ajrb_ram and ajrb_ctrl.
//
// An item is taken when start is high and busy is low. A push or a refused drain
// gives one result, with valid high for one cycle, in the cycle after the item is
// taken; pushes can be taken every cycle while busy is low. A drain with at least
// BLOCK_SIZE samples held gives BLOCK_SIZE results on consecutive cycles, the first
// in the cycle after the item is taken, and holds busy high while the rest of the
// block is read: the ring sits in one RAM with a single read port, read one sample
// per cycle. The receiver cannot stall, so every result must be taken in the cycle
// it is shown. overflow_count and fill_level show the live counters and are
// meaningful while valid is high. The ring needs no clearing after reset.
module audio_jitter_ring_buffer_top #(
  parameter int BLOCK_SIZE = ajrb_pkg::BLOCK_SIZE_DEF,
  parameter int RING_DEPTH = ajrb_pkg::RING_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 mode,
  input  logic [7:0]                           high_byte,
  input  logic [7:0]                           low_byte,
  output logic                                 valid,
  output logic [1:0]                           kind,
  output logic [ajrb_pkg::SAMPLE_W-1:0]        sample,
  output logic                                 last,
  output logic                                 overflowed,
  output logic [ajrb_pkg::COUNT_W-1:0]         overflow_count,
  output logic [$clog2(RING_DEPTH + 1)-1:0]    fill_level
);

  localparam int PW = $clog2(RING_DEPTH);

  logic                          ram_we, ram_re;
  logic [PW-1:0]                 ram_waddr, ram_raddr;
  logic [ajrb_pkg::SAMPLE_W-1:0] ram_wdata, ram_rdata;
  ajrb_pkg::res_tag_t            tag_next, tag;

  ajrb_ctrl #(
    .BLOCK_SIZE(BLOCK_SIZE),
    .RING_DEPTH(RING_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .high_byte (high_byte),
    .low_byte  (low_byte),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .tag_next  (tag_next),
    .held      (fill_level),
    .drop_count(overflow_count)
  );

  ajrb_ram #(
    .WIDTH(ajrb_pkg::SAMPLE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else begin
      tag <= tag_next;
    end
  end

  assign valid      = tag.valid;
  assign kind       = tag.kind;
  assign last       = tag.last;
  assign overflowed = tag.overflowed;
  assign sample     = (tag.valid && tag.kind == ajrb_pkg::KIND_SAMPLE) ? ram_rdata : '0;

endmodule

// File: rtl/ajrb_checker.sv
// Port-level checker for the audio jitter ring buffer, bound to the top level.
// Depends on ajrb_pkg and audio_jitter_ring_buffer_top.
module ajrb_checker #(
  parameter int RING_DEPTH = ajrb_pkg::RING_DEPTH_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              mode,
  input logic                              valid,
  input logic [1:0]                        kind,
  input logic [ajrb_pkg::SAMPLE_W-1:0]     sample,
  input logic                              last,
  input logic [$clog2(RING_DEPTH + 1)-1:0] fill_level
);

  // every cycle of a drain shows a sample item
  a_busy_shows_sample: assert property (@(posedge clk) disable iff (rst)
    busy |-> (valid && kind == ajrb_pkg::KIND_SAMPLE))
    else $error("busy without a drained sample on the result ports");

  a_push_ack: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == ajrb_pkg::MODE_PUSH)
      |=> (valid && kind == ajrb_pkg::KIND_PUSH && last))
    else $error("push item not acknowledged in the next cycle");

  a_block_continues: assert property (@(posedge clk) disable iff (rst)
    (valid && kind == ajrb_pkg::KIND_SAMPLE && !last)
      |=> (valid && kind == ajrb_pkg::KIND_SAMPLE))
    else $error("drained block broken before its last item");

  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && kind != ajrb_pkg::KIND_SAMPLE) |-> (sample == '0 && last))
    else $error("non-sample result with sample data or without last");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    valid |-> (32'(fill_level) <= 32'(RING_DEPTH)))
    else $error("fill level above ring depth");

endmodule

bind audio_jitter_ring_buffer_top ajrb_checker #(
  .RING_DEPTH(RING_DEPTH)
) u_ajrb_checker (.*);

// File: tb/sv/audio_jitter_ring_buffer_top_test.sv
// Self-checking testbench for audio_jitter_ring_buffer_top: a ring tracker class predicts
// the results of each accepted item and checks what the block emits. Depends on ajrb_pkg
// and the RTL of the block.

class jitter_ring_tracker;
  typedef struct {
    ajrb_pkg::kind_t kind;
    bit [15:0]       sample;
    bit              last;
    bit              overflowed;
    bit [31:0]       drops;
    bit [7:0]        fill;
  } ring_result_t;

  ring_result_t expected_results[$];
  bit [15:0]    ring_words[ajrb_pkg::RING_DEPTH_DEF];
  int           wr_idx;
  int           rd_idx;
  int           held;
  bit [31:0]    drops;
  int           mismatch_count;

  function new();
    wr_idx         = 0;
    rd_idx         = 0;
    held           = 0;
    drops          = '0;
    mismatch_count = 0;
  endfunction

  function void queue_result(ajrb_pkg::kind_t kind, bit [15:0] sample, bit last, bit ovf);
    ring_result_t r;
    r.kind       = kind;
    r.sample     = sample;
    r.last       = last;
    r.overflowed = ovf;
    r.drops      = drops;
    r.fill       = held[7:0];
    expected_results.push_back(r);
  endfunction

  // Note an accepted item and queue every result it should cause.
  function void take_item(logic mode, logic [7:0] hi, logic [7:0] lo);
    bit        ovf;
    bit [15:0] word;
    if (mode == ajrb_pkg::MODE_PUSH) begin
      ovf = (held >= ajrb_pkg::RING_DEPTH_DEF);
      if (ovf) begin
        // full ring: oldest sample goes, fill stays at depth
        drops++;
        rd_idx = (rd_idx + 1) % ajrb_pkg::RING_DEPTH_DEF;
      end else begin
        held++;
      end
      ring_words[wr_idx] = {hi, lo};
      wr_idx = (wr_idx + 1) % ajrb_pkg::RING_DEPTH_DEF;
      queue_result(ajrb_pkg::KIND_PUSH, 16'h0000, 1'b1, ovf);
    end else if (held < ajrb_pkg::BLOCK_SIZE_DEF) begin
      queue_result(ajrb_pkg::KIND_REFUSED, 16'h0000, 1'b1, 1'b0);
    end else begin
      for (int i = 0; i < ajrb_pkg::BLOCK_SIZE_DEF; i++) begin
        word   = ring_words[rd_idx];
        rd_idx = (rd_idx + 1) % ajrb_pkg::RING_DEPTH_DEF;
        held--;
        queue_result(ajrb_pkg::KIND_SAMPLE, word, i == ajrb_pkg::BLOCK_SIZE_DEF - 1, 1'b0);
      end
    end
  endfunction

  task report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task check_result(logic [1:0] kind, logic [15:0] sample, logic last, logic ovf,
                    logic [31:0] count, logic [7:0] fill);
    ring_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with none expected, kind %0d", kind));
      return;
    end
    want = expected_results.pop_front();
    if (kind !== want.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
    if (sample !== want.sample)
      report_mismatch($sformatf("sample %h, expected %h", sample, want.sample));
    if (last !== want.last)
      report_mismatch($sformatf("last %b, expected %b", last, want.last));
    if (ovf !== want.overflowed)
      report_mismatch($sformatf("overflowed %b, expected %b", ovf, want.overflowed));
    if (count !== want.drops)
      report_mismatch($sformatf("overflow_count %0d, expected %0d", count, want.drops));
    if (fill !== want.fill)
      report_mismatch($sformatf("fill_level %0d, expected %0d", fill, want.fill));
  endtask
endclass

module audio_jitter_ring_buffer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_SIZE   = ajrb_pkg::BLOCK_SIZE_DEF;
  localparam int RING_DEPTH   = ajrb_pkg::RING_DEPTH_DEF;
  localparam int TARGET_ITEMS = 450;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              mode = ajrb_pkg::MODE_PUSH;
  logic [7:0]                        high_byte = 8'h00;
  logic [7:0]                        low_byte = 8'h00;
  logic                              busy;
  logic                              valid;
  logic [1:0]                        kind;
  logic [ajrb_pkg::SAMPLE_W-1:0]     sample;
  logic                              last;
  logic                              overflowed;
  logic [ajrb_pkg::COUNT_W-1:0]      overflow_count;
  logic [$clog2(RING_DEPTH + 1)-1:0] fill_level;

  jitter_ring_tracker tracker;
  int                 items_sent = 0;
  bit                 quiet = 1'b0;

  audio_jitter_ring_buffer_top #(
    .BLOCK_SIZE(BLOCK_SIZE),
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .high_byte(high_byte),
    .low_byte(low_byte),
    .valid(valid),
    .kind(kind),
    .sample(sample),
    .last(last),
    .overflowed(overflowed),
    .overflow_count(overflow_count),
    .fill_level(fill_level)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && valid === 1'b1)
      tracker.check_result(kind, sample, last, overflowed, overflow_count, fill_level);
  end

  // Mostly back-to-back, some short pauses, a few long ones.
  function int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task send_item(logic m, logic [7:0] hi, logic [7:0] lo);
    int gap;
    start     <= 1'b1;
    mode      <= m;
    high_byte <= hi;
    low_byte  <= lo;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.take_item(m, hi, lo);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    int pick;
    int seg;
    int waited;
    int burst;
    tracker = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: refusal on empty ring, byte extremes, refusal with a few held
    send_item(ajrb_pkg::MODE_DRAIN, 8'hFF, 8'hFF);
    send_item(ajrb_pkg::MODE_PUSH, 8'hFF, 8'hFF);
    send_item(ajrb_pkg::MODE_PUSH, 8'h00, 8'h00);
    send_item(ajrb_pkg::MODE_PUSH, 8'h00, 8'hFF);
    send_item(ajrb_pkg::MODE_PUSH, 8'hFF, 8'h00);
    send_item(ajrb_pkg::MODE_PUSH, 8'hA5, 8'h5A);
    send_item(ajrb_pkg::MODE_PUSH, 8'h5A, 8'hA5);
    send_item(ajrb_pkg::MODE_PUSH, 8'h80, 8'h01);
    send_item(ajrb_pkg::MODE_PUSH, 8'h01, 8'h80);
    send_item(ajrb_pkg::MODE_DRAIN, 8'h00, 8'h00);

    // random: push bursts, long bursts that overrun the ring, and drain runs
    seg = 0;
    while (items_sent < TARGET_ITEMS) begin
      pick  = (seg == 0) ? 0 : $urandom_range(0, 9);
      quiet = ($urandom_range(0, 3) == 0);
      if (pick == 0) begin
        burst = $urandom_range(100, 180);
      end else if (pick <= 5) begin
        burst = $urandom_range(1, 40);
      end else begin
        burst = $urandom_range(1, 3);
      end
      // keep the total close to the target
      if (burst > TARGET_ITEMS - items_sent) burst = TARGET_ITEMS - items_sent;
      if (pick <= 5) begin
        repeat (burst)
          send_item(ajrb_pkg::MODE_PUSH, 8'($urandom), 8'($urandom));
      end else begin
        repeat (burst)
          send_item(ajrb_pkg::MODE_DRAIN, 8'($urandom), 8'($urandom));
      end
      seg++;
    end
    start <= 1'b0;

    waited = 0;
    while (tracker.expected_results.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (BLOCK_SIZE + 4) @(posedge clk);
    while (tracker.expected_results.size() != 0) begin
      tracker.report_mismatch("expected result never arrived");
      void'(tracker.expected_results.pop_front());
    end

    if (tracker.mismatch_count == 0) begin
      $display("PASS audio_jitter_ring_buffer_top");
    end else begin
      $display("FAIL audio_jitter_ring_buffer_top");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL audio_jitter_ring_buffer_top");
    $finish;
  end
endmodule
